>>> src/vle_branch_link_unit_assert.svh
// Assertion macros shared by the branch and link unit RTL.
`ifndef VLE_BRANCH_LINK_UNIT_ASSERT_SVH
`define VLE_BRANCH_LINK_UNIT_ASSERT_SVH

// The consequent is checked in the same cycle as the antecedent.
`define VLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent is checked in the cycle after the antecedent.
`define VLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/vle_pkg.sv
// Types and constants for the branch and link unit.
package vle_pkg;

  typedef enum logic [3:0] {
    OP_E_B     = 4'd0,
    OP_SE_B    = 4'd1,
    OP_E_BC    = 4'd2,
    OP_SE_BC   = 4'd3,
    OP_SE_BCTR = 4'd4,
    OP_SE_BLR  = 4'd5,
    OP_MTCTR   = 4'd6,
    OP_MTLR    = 4'd7,
    OP_MFCTR   = 4'd8,
    OP_MFLR    = 4'd9,
    OP_MCRF    = 4'd10,
    OP_BTSTI   = 4'd11
  } op_e;

  localparam logic [31:0] LongInstrBytes  = 32'd4;
  localparam logic [31:0] ShortInstrBytes = 32'd2;
  localparam logic [31:0] TargetMask      = 32'hFFFF_FFFE;
  localparam logic [3:0]  CrEq            = 4'b0010;
  localparam logic [3:0]  CrGt            = 4'b0100;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [31:0] pc;
    logic [23:0] disp;
    logic [4:0]  cond_bit;
    logic [1:0]  branch_options;
    logic        link;
    logic [2:0]  field_dst;
    logic [2:0]  field_src;
    logic [31:0] gpr_value;
    logic [4:0]  test_bit;
    logic        summary_overflow;
  } in_item_t;

  typedef struct packed {
    logic        redirect;
    logic [31:0] next_pc;
    logic [31:0] read_value;
    logic [31:0] cond_now;
  } out_item_t;

endpackage

>>> src/vle_branch_link_unit.sv
// Branch and link unit: link, count and condition registers with one instruction per item.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------
//   input    | in_valid_i / in_stall_o   | in_item_i  (vle_pkg::in_item_t)
//   output   | out_valid_o / out_stall_i | out_item_o (vle_pkg::out_item_t)
//
// Each item is decoded and executed in the cycle it is accepted; its result appears
// in the output register in the following cycle. One item per cycle is sustained
// while the output side does not stall, limited only by the single output register.
// Reset clears the link, count and condition registers and the output valid.
// An input item is stalled only while a result is held and the output side stalls.
`include "vle_branch_link_unit_assert.svh"

module vle_branch_link_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  vle_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vle_pkg::out_item_t out_item_o
);
  import vle_pkg::*;

  logic [31:0] link_q, link_d;
  logic [31:0] count_q, count_d;
  logic [31:0] cond_q, cond_d;
  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;
  logic        accept;

  op_e         op;
  logic [31:0] ext8, ext15, ext24;
  logic        cr_bit;
  logic [31:0] count_dec;
  logic        use_cnt, sense, cnt_ok, cnd_ok;
  logic [4:0]  src_lsb, dst_lsb;
  logic [3:0]  field_val;
  logic        test_hit;
  logic [3:0]  test_field;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Displacements are shifted left once, then sign extended from the shifted width.
  assign ext8  = {{23{in_item_i.disp[7]}}, in_item_i.disp[7:0], 1'b0};
  assign ext15 = {{16{in_item_i.disp[14]}}, in_item_i.disp[14:0], 1'b0};
  assign ext24 = {{7{in_item_i.disp[23]}}, in_item_i.disp[23:0], 1'b0};

  // Bit 0 of the condition register is its most significant bit.
  assign cr_bit = cond_q[5'd31 - in_item_i.cond_bit];

  assign use_cnt   = in_item_i.branch_options[1];
  assign sense     = in_item_i.branch_options[0];
  // A zero count is left at zero rather than wrapping.
  assign count_dec = (count_q != 32'd0) ? count_q - 32'd1 : count_q;
  assign cnt_ok    = !use_cnt || ((count_dec != 32'd0) ^ sense);
  assign cnd_ok    = use_cnt || (cr_bit == sense);

  assign src_lsb    = 5'd28 - {in_item_i.field_src, 2'b00};
  assign dst_lsb    = 5'd28 - {in_item_i.field_dst, 2'b00};
  assign field_val  = cond_q[src_lsb +: 4];
  assign test_hit   = in_item_i.gpr_value[5'd31 - in_item_i.test_bit];
  assign test_field = (test_hit ? CrGt : CrEq) | {3'b000, in_item_i.summary_overflow};

  assign op = op_e'(in_item_i.opcode);

  always_comb begin
    link_d                = link_q;
    count_d               = count_q;
    cond_d                = cond_q;
    out_item_d.redirect   = 1'b0;
    out_item_d.next_pc    = 32'd0;
    out_item_d.read_value = 32'd0;
    case (op)
      OP_E_B: begin
        out_item_d.redirect = 1'b1;
        out_item_d.next_pc  = in_item_i.pc + ext24;
        if (in_item_i.link) link_d = in_item_i.pc + LongInstrBytes;
      end
      OP_SE_B: begin
        out_item_d.redirect = 1'b1;
        out_item_d.next_pc  = in_item_i.pc + ext8;
        if (in_item_i.link) link_d = in_item_i.pc + ShortInstrBytes;
      end
      OP_E_BC: begin
        if (use_cnt) count_d = count_dec;
        out_item_d.redirect = 1'b1;
        out_item_d.next_pc  = (cnt_ok && cnd_ok) ? in_item_i.pc + ext15
                                                 : in_item_i.pc + LongInstrBytes;
        if (in_item_i.link) link_d = in_item_i.pc + LongInstrBytes;
      end
      OP_SE_BC: begin
        out_item_d.redirect = 1'b1;
        out_item_d.next_pc  = (cr_bit == sense) ? in_item_i.pc + ext8
                                                : in_item_i.pc + ShortInstrBytes;
      end
      OP_SE_BCTR: begin
        out_item_d.redirect = 1'b1;
        out_item_d.next_pc  = count_q & TargetMask;
        if (in_item_i.link) link_d = in_item_i.pc + ShortInstrBytes;
      end
      OP_SE_BLR: begin
        // The target comes from the link value before any new link write.
        out_item_d.redirect = 1'b1;
        out_item_d.next_pc  = link_q & TargetMask;
        if (in_item_i.link) link_d = in_item_i.pc + ShortInstrBytes;
      end
      OP_MTCTR: count_d = in_item_i.gpr_value;
      OP_MTLR:  link_d  = in_item_i.gpr_value;
      OP_MFCTR: out_item_d.read_value = count_q;
      OP_MFLR:  out_item_d.read_value = link_q;
      OP_MCRF:  cond_d[dst_lsb +: 4] = field_val;
      OP_BTSTI: cond_d[31:28] = test_field;
      default: begin
      end
    endcase
    out_item_d.cond_now = cond_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q      <= 32'd0;
      count_q     <= 32'd0;
      cond_q      <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        link_q  <= link_d;
        count_q <= count_d;
        cond_q  <= cond_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `VLE_ASSERT_NEXT(a_mtctr_loads_count, clk_i, rst_ni,
    accept && (in_item_i.opcode == OP_MTCTR), count_q == $past(in_item_i.gpr_value))
  `VLE_ASSERT_NEXT(a_mfctr_reads_count, clk_i, rst_ni,
    accept && (in_item_i.opcode == OP_MFCTR), out_item_q.read_value == $past(count_q))
  `VLE_ASSERT_NEXT(a_branch_redirects, clk_i, rst_ni,
    accept && (in_item_i.opcode <= OP_SE_BLR), out_valid_q && out_item_q.redirect)
  `VLE_ASSERT_NEXT(a_result_shows_cond, clk_i, rst_ni,
    accept, out_item_q.cond_now == cond_q)
  `VLE_ASSERT_NOW(a_stall_needs_result, clk_i, rst_ni, in_stall_o, out_valid_q)

endmodule

>>> test/tb_vle_branch_link_unit.sv
// Self-checking testbench for the branch and link unit with a register-level scoreboard.
`timescale 1ns / 1ps

module tb_vle_branch_link_unit;
  import vle_pkg::*;

  class branch_link_scoreboard;
    logic [31:0] link_q;
    logic [31:0] count_q;
    logic [31:0] cond_q;
    out_item_t   expected_q[$];
    int unsigned mismatches;

    function new();
      link_q      = '0;
      count_q     = '0;
      cond_q      = '0;
      mismatches  = 0;
    endfunction

    // Displacements are doubled and then sign-extended from the doubled width.
    function logic [31:0] offset24(logic [23:0] d);
      return {{7{d[23]}}, d, 1'b0};
    endfunction

    function logic [31:0] offset15(logic [23:0] d);
      return {{16{d[14]}}, d[14:0], 1'b0};
    endfunction

    function logic [31:0] offset8(logic [23:0] d);
      return {{23{d[7]}}, d[7:0], 1'b0};
    endfunction

    function void note_item(in_item_t it);
      out_item_t  res;
      logic       use_cnt;
      logic       sense;
      logic       cnt_ok;
      logic       cnd_ok;
      logic [3:0] fld;
      res = '0;
      case (it.opcode)
        OP_E_B: begin
          res.redirect = 1'b1;
          res.next_pc  = it.pc + offset24(it.disp);
          if (it.link) link_q = it.pc + LongInstrBytes;
        end
        OP_SE_B: begin
          res.redirect = 1'b1;
          res.next_pc  = it.pc + offset8(it.disp);
          if (it.link) link_q = it.pc + ShortInstrBytes;
        end
        OP_E_BC: begin
          use_cnt = it.branch_options[1];
          sense   = it.branch_options[0];
          // A zero count is left at zero rather than wrapping.
          if (use_cnt && count_q != 0) count_q = count_q - 1;
          cnt_ok = !use_cnt || ((count_q != 0) != sense);
          cnd_ok = use_cnt || (cond_q[31 - it.cond_bit] == sense);
          res.redirect = 1'b1;
          res.next_pc  = (cnt_ok && cnd_ok) ? it.pc + offset15(it.disp)
                                            : it.pc + LongInstrBytes;
          if (it.link) link_q = it.pc + LongInstrBytes;
        end
        OP_SE_BC: begin
          res.redirect = 1'b1;
          res.next_pc  = (cond_q[31 - it.cond_bit] == it.branch_options[0])
                         ? it.pc + offset8(it.disp) : it.pc + ShortInstrBytes;
        end
        OP_SE_BCTR: begin
          res.redirect = 1'b1;
          res.next_pc  = count_q & TargetMask;
          if (it.link) link_q = it.pc + ShortInstrBytes;
        end
        OP_SE_BLR: begin
          // The target comes from the link value before it is overwritten.
          res.redirect = 1'b1;
          res.next_pc  = link_q & TargetMask;
          if (it.link) link_q = it.pc + ShortInstrBytes;
        end
        OP_MTCTR: count_q = it.gpr_value;
        OP_MTLR:  link_q = it.gpr_value;
        OP_MFCTR: res.read_value = count_q;
        OP_MFLR:  res.read_value = link_q;
        OP_MCRF: begin
          fld = cond_q[(7 - it.field_src) * 4 +: 4];
          cond_q[(7 - it.field_dst) * 4 +: 4] = fld;
        end
        OP_BTSTI: begin
          fld         = it.gpr_value[31 - it.test_bit] ? CrGt : CrEq;
          fld[0]      = it.summary_overflow;
          cond_q[31:28] = fld;
        end
        default: ;
      endcase
      res.cond_now = cond_q;
      expected_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: redirect=%0d next_pc=%h read_value=%h cond_now=%h",
                   got.redirect, got.next_pc, got.read_value, got.cond_now);
        return;
      end
      want = expected_q.pop_front();
      if (got.redirect !== want.redirect || got.next_pc !== want.next_pc ||
          got.read_value !== want.read_value || got.cond_now !== want.cond_now) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t:", $realtime);
          $display("  expected redirect=%0d next_pc=%h read_value=%h cond_now=%h",
                   want.redirect, want.next_pc, want.read_value, want.cond_now);
          $display("  actual   redirect=%0d next_pc=%h read_value=%h cond_now=%h",
                   got.redirect, got.next_pc, got.read_value, got.cond_now);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 64;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  branch_link_scoreboard sb = new();
  bit          calm;
  bit          hold_req;
  int unsigned cycle_count;

  vle_branch_link_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    if ($urandom_range(0, 19) == 0) it.opcode = 4'($urandom_range(12, 15));
    else it.opcode = 4'($urandom_range(0, 11));
    it.pc               = $urandom;
    it.disp             = 24'($urandom);
    it.cond_bit         = 5'($urandom);
    it.branch_options   = 2'($urandom);
    it.link             = 1'($urandom);
    it.field_dst        = 3'($urandom);
    it.field_src        = 3'($urandom);
    it.gpr_value        = $urandom;
    it.test_bit         = 5'($urandom);
    it.summary_overflow = 1'($urandom);
    // Small counts let the counting branch run down to zero often.
    if (it.opcode == OP_MTCTR && $urandom_range(0, 2) != 0)
      it.gpr_value = $urandom_range(0, 3);
    return it;
  endfunction

  function automatic in_item_t op_item(op_e op);
    in_item_t it;
    it = rand_item();
    it.opcode = op;
    return it;
  endfunction

  // Called at a rising edge; returns at the edge where the item was taken.
  task automatic send_item(input in_item_t it, input bit may_idle);
    int unsigned gap;
    gap = (may_idle && !calm) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic send_random(input int unsigned n, input bit may_idle);
    repeat (n) send_item(rand_item(), may_idle);
  endtask

  task automatic run_directed();
    in_item_t it;
    send_item(op_item(OP_MFCTR), 1'b1);
    send_item(op_item(OP_MFLR), 1'b1);
    it = op_item(OP_E_B);
    it.pc = 32'hFFFF_FFFC; it.disp = 24'h7F_FFFF; it.link = 1'b1;
    send_item(it, 1'b1);
    it = op_item(OP_E_B);
    it.pc = '0; it.disp = 24'h80_0000; it.link = 1'b0;
    send_item(it, 1'b1);
    it = op_item(OP_SE_B);
    it.disp = 24'h00_007F; it.link = 1'b1;
    send_item(it, 1'b1);
    it = op_item(OP_SE_B);
    it.disp = 24'hFF_FF80; it.link = 1'b0;
    send_item(it, 1'b1);
    it = op_item(OP_MTCTR);
    it.gpr_value = 32'd2;
    send_item(it, 1'b1);
    // Count down through one and zero, then branch on a count held at zero.
    it = op_item(OP_E_BC);
    it.branch_options = 2'b10; it.disp = 24'h00_3FFF;
    send_item(it, 1'b1);
    it.branch_options = 2'b10; it.pc = 32'h0000_1000;
    send_item(it, 1'b1);
    it.branch_options = 2'b11; it.link = 1'b1;
    send_item(it, 1'b1);
    it = op_item(OP_BTSTI);
    it.gpr_value = 32'h8000_0000; it.test_bit = 5'd0; it.summary_overflow = 1'b1;
    send_item(it, 1'b1);
    it.gpr_value = '0; it.test_bit = 5'd31; it.summary_overflow = 1'b0;
    send_item(it, 1'b1);
    it.gpr_value = 32'd1; it.summary_overflow = 1'b1;
    send_item(it, 1'b1);
    it = op_item(OP_E_BC);
    it.branch_options = 2'b00; it.cond_bit = 5'd1; it.disp = 24'h00_4000; it.link = 1'b1;
    send_item(it, 1'b1);
    it.branch_options = 2'b01; it.disp = 24'hFF_7FFF;
    send_item(it, 1'b1);
    it = op_item(OP_SE_BC);
    it.branch_options = 2'b11; it.cond_bit = 5'd1; it.disp = 24'h00_00FF; it.link = 1'b1;
    send_item(it, 1'b1);
    it.branch_options = 2'b10;
    send_item(it, 1'b1);
    it = op_item(OP_MTLR);
    it.gpr_value = 32'hFFFF_FFFF;
    send_item(it, 1'b1);
    it = op_item(OP_SE_BLR);
    it.link = 1'b1;
    send_item(it, 1'b1);
    send_item(op_item(OP_MFLR), 1'b1);
    it = op_item(OP_MTCTR);
    it.gpr_value = 32'hFFFF_FFFF;
    send_item(it, 1'b1);
    it = op_item(OP_SE_BCTR);
    it.link = 1'b1;
    send_item(it, 1'b1);
    it = op_item(OP_MCRF);
    it.field_dst = 3'd7; it.field_src = 3'd0;
    send_item(it, 1'b1);
    it.field_dst = 3'd0; it.field_src = 3'd7;
    send_item(it, 1'b1);
    it = rand_item();
    it.opcode = 4'd12; it.link = 1'b1;
    send_item(it, 1'b1);
    it.opcode = 4'd15;
    send_item(it, 1'b1);
  endtask

  // Receiver: random stall runs, a long hold-off on request, none while calm.
  initial begin
    int unsigned hold_left;
    int unsigned run_left;
    bit          stalling;
    hold_left = 0;
    run_left  = 0;
    stalling  = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = HoldCycles;
        stalling    = 1'b1;
        out_stall_i <= 1'b1;
      end else if (calm) begin
        stalling    = 1'b0;
        out_stall_i <= 1'b0;
      end else if (run_left != 0) begin
        run_left--;
      end else if (!stalling && $urandom_range(0, 2) == 0) begin
        stalling    = 1'b1;
        run_left    = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        stalling    = 1'b0;
        run_left    = $urandom_range(0, 15);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_vle_branch_link_unit: errors");
    $finish;
  end

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    run_directed();
    send_random(600, 1'b1);
    // The receiver holds off while items keep coming, so the input backs up.
    hold_req = 1'b1;
    send_random(40, 1'b0);
    wait_all_results();
    calm = 1'b1;
    send_random(400, 1'b1);
    calm = 1'b0;
    send_random(385, 1'b1);
    wait_all_results();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_vle_branch_link_unit: clean");
    end else begin
      $display("tb_vle_branch_link_unit: errors");
    end
    $finish;
  end
endmodule
